// ===== sv/i2cras_pkg.sv =====
package i2cras_pkg;

    localparam int ACT_W  = 3;
    localparam int DEV_W  = 7;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 6;
    localparam int POS_W  = 5;
    localparam int MODE_W = 3;

    localparam logic [ACT_W-1:0] ACT_LOAD     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START_WR = 3'd1;
    localparam logic [ACT_W-1:0] ACT_START_RD = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TX_READY = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RX_BYTE  = 3'd4;

    localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REG    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SWITCH = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TXDATA = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RXDATA = 3'd4;

    localparam logic [CNT_W-1:0] RX_LIMIT = 6'd32;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [DEV_W-1:0]  dev_address;
        logic [BYTE_W-1:0] register_address;
        logic [CNT_W-1:0]  byte_count;
        logic [BYTE_W-1:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic              accepted;
        logic              start_cond;
        logic              stop_cond;
        logic              transmit_dir;
        logic              send_valid;
        logic [BYTE_W-1:0] send_data;
        logic [DEV_W-1:0]  target_address;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_data;
        logic [POS_W-1:0]  rx_position;
        logic              done_res;
        logic              busy_res;
    } t_out_word;

endpackage

// ===== sv/i2cras_if.sv =====
interface i2cras_in_if;
    logic                valid;
    logic                ready;
    i2cras_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cras_out_if;
    logic                 valid;
    logic                 ready;
    i2cras_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/i2c_register_access_sequencer.sv =====
// A word taken into the input register gives its result word from the result register.
// Throughput: one word per cycle unless the result side stalls; input register, one mode step, result register.
// Transmit store read is prefetched each cycle at the next send index, with write bypass.
// Reset (i_rst_n low, synchronous): mode idle, latches, counters and pointers cleared,
// both pipeline stages empty. Transmit store contents are not cleared.
module i2c_register_access_sequencer #(
    parameter int BUF_DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    i2cras_in_if.sink      i_in,
    i2cras_out_if.source   o_out
);

    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int SW = (CW > i2cras_pkg::CNT_W) ? CW : i2cras_pkg::CNT_W;

    logic                              r_in_vld;
    i2cras_pkg::t_in_word              r_in;
    logic                              r_out_vld;
    i2cras_pkg::t_out_word             r_out;
    i2cras_pkg::t_out_word             n_out;

    logic [i2cras_pkg::MODE_W-1:0]     r_mode,    n_mode;
    logic [i2cras_pkg::BYTE_W-1:0]     r_reg,     n_reg;
    logic [i2cras_pkg::DEV_W-1:0]      r_dev,     n_dev;
    logic [i2cras_pkg::CNT_W-1:0]      r_rx_rem,  n_rx_rem;
    logic [CW-1:0]                     r_tx_rem,  n_tx_rem;
    logic [i2cras_pkg::POS_W-1:0]      r_rx_idx,  n_rx_idx;
    logic [CW-1:0]                     r_tx_idx,  n_tx_idx;
    logic [CW-1:0]                     r_fill,    n_fill;

    logic [i2cras_pkg::BYTE_W-1:0]     r_store [BUF_DEPTH];
    logic [i2cras_pkg::BYTE_W-1:0]     r_rd;
    logic                              r_byp;
    logic [i2cras_pkg::BYTE_W-1:0]     r_byp_data;
    logic [i2cras_pkg::BYTE_W-1:0]     rd_byte;

    logic                              fire;
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic [AW-1:0]                     rd_addr;
    logic [i2cras_pkg::CNT_W-1:0]      rx_dec;

    assign fire       = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || fire;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    assign wr_en   = fire && (r_in.action == i2cras_pkg::ACT_LOAD)
                     && (r_fill < CW'(BUF_DEPTH));
    assign wr_addr = r_fill[AW-1:0];
    assign rd_addr = n_tx_idx[AW-1:0];
    assign rd_byte = r_byp ? r_byp_data : r_rd;
    assign rx_dec  = r_rx_rem - i2cras_pkg::CNT_W'(1);

    always_comb begin
        n_mode   = r_mode;
        n_reg    = r_reg;
        n_dev    = r_dev;
        n_rx_rem = r_rx_rem;
        n_tx_rem = r_tx_rem;
        n_rx_idx = r_rx_idx;
        n_tx_idx = r_tx_idx;
        n_fill   = r_fill;
        n_out    = '0;
        n_out.accepted = 1'b1;
        if (fire) begin
            unique case (r_in.action) inside
                i2cras_pkg::ACT_LOAD: begin
                    if (r_fill < CW'(BUF_DEPTH)) begin
                        n_fill = r_fill + CW'(1);
                    end
                end
                i2cras_pkg::ACT_START_WR, i2cras_pkg::ACT_START_RD: begin
                    if (r_mode != i2cras_pkg::MODE_IDLE) begin
                        n_out.accepted = 1'b0;
                    end else begin
                        n_mode   = i2cras_pkg::MODE_REG;
                        n_reg    = r_in.register_address;
                        n_dev    = r_in.dev_address;
                        n_rx_idx = '0;
                        n_tx_idx = '0;
                        n_fill   = '0;
                        if (r_in.action == i2cras_pkg::ACT_START_WR) begin
                            n_rx_rem = '0;
                            if (SW'(r_in.byte_count) > SW'(BUF_DEPTH)) begin
                                n_tx_rem = CW'(BUF_DEPTH);
                            end else begin
                                n_tx_rem = CW'(r_in.byte_count);
                            end
                        end else begin
                            n_tx_rem = '0;
                            n_rx_rem = (r_in.byte_count > i2cras_pkg::RX_LIMIT)
                                       ? i2cras_pkg::RX_LIMIT : r_in.byte_count;
                        end
                        n_out.start_cond     = 1'b1;
                        n_out.transmit_dir   = 1'b1;
                        n_out.target_address = r_in.dev_address;
                    end
                end
                i2cras_pkg::ACT_TX_READY: begin
                    if (r_mode == i2cras_pkg::MODE_REG) begin
                        n_out.transmit_dir = 1'b1;
                        n_out.send_valid   = 1'b1;
                        n_out.send_data    = r_reg;
                        n_mode = (r_rx_rem != '0) ? i2cras_pkg::MODE_SWITCH
                                                  : i2cras_pkg::MODE_TXDATA;
                    end else if (r_mode == i2cras_pkg::MODE_SWITCH) begin
                        n_mode               = i2cras_pkg::MODE_RXDATA;
                        n_out.start_cond     = 1'b1;
                        n_out.target_address = r_dev;
                        n_out.stop_cond      = (r_rx_rem == i2cras_pkg::CNT_W'(1));
                    end else if (r_mode == i2cras_pkg::MODE_TXDATA) begin
                        if (r_tx_rem != '0) begin
                            n_out.transmit_dir = 1'b1;
                            n_out.send_valid   = 1'b1;
                            n_out.send_data    = rd_byte;
                            n_tx_idx = r_tx_idx + CW'(1);
                            n_tx_rem = r_tx_rem - CW'(1);
                        end else begin
                            n_out.stop_cond = 1'b1;
                            n_out.done_res  = 1'b1;
                            n_mode          = i2cras_pkg::MODE_IDLE;
                        end
                    end
                end
                i2cras_pkg::ACT_RX_BYTE: begin
                    if (r_mode == i2cras_pkg::MODE_RXDATA) begin
                        if (r_rx_rem != '0) begin
                            n_out.rx_valid    = 1'b1;
                            n_out.rx_data     = r_in.data_byte;
                            n_out.rx_position = r_rx_idx;
                            n_rx_idx = r_rx_idx + i2cras_pkg::POS_W'(1);
                            n_rx_rem = rx_dec;
                        end
                        if (n_rx_rem == i2cras_pkg::CNT_W'(1)) begin
                            n_out.stop_cond = 1'b1;
                        end else if (n_rx_rem == '0) begin
                            n_mode         = i2cras_pkg::MODE_IDLE;
                            n_out.done_res = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        n_out.busy_res = (n_mode != i2cras_pkg::MODE_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_mode    <= i2cras_pkg::MODE_IDLE;
            r_reg     <= '0;
            r_dev     <= '0;
            r_rx_rem  <= '0;
            r_tx_rem  <= '0;
            r_rx_idx  <= '0;
            r_tx_idx  <= '0;
            r_fill    <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            r_mode   <= n_mode;
            r_reg    <= n_reg;
            r_dev    <= n_dev;
            r_rx_rem <= n_rx_rem;
            r_tx_rem <= n_tx_rem;
            r_rx_idx <= n_rx_idx;
            r_tx_idx <= n_tx_idx;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    // transmit store, read registered at the next send index, ahead of its use
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= r_in.data_byte;
        end
        r_rd       <= r_store[rd_addr];
        r_byp      <= wr_en && (wr_addr == rd_addr);
        r_byp_data <= r_in.data_byte;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(BUF_DEPTH))
        else $error("fill pointer beyond store depth");

    a_tx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_tx_idx) + SW'(r_tx_rem)) <= SW'(BUF_DEPTH))
        else $error("send index plus remaining count beyond store depth");

    a_rx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_rem <= i2cras_pkg::RX_LIMIT)
        else $error("receive count beyond limit");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && n_out.done_res |=> r_mode == i2cras_pkg::MODE_IDLE)
        else $error("transaction done but mode not idle");

    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !n_out.accepted |=> $stable(r_mode) && $stable(r_fill))
        else $error("rejected start changed state");

endmodule

// ===== test/i2cras_txn_check.sv =====
module i2cras_txn_check #(
    parameter int BUF_DEPTH = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    i2cras_in_if  i_words,
    i2cras_out_if i_results,
    output int    o_err_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [i2cras_pkg::MODE_W-1:0] seq_mode;
    logic [i2cras_pkg::BYTE_W-1:0] reg_q;
    logic [i2cras_pkg::DEV_W-1:0]  dev_q;
    logic [i2cras_pkg::CNT_W-1:0]  rx_left;
    logic [i2cras_pkg::CNT_W-1:0]  tx_left;
    logic [i2cras_pkg::POS_W-1:0]  rx_idx;
    logic [i2cras_pkg::POS_W-1:0]  tx_idx;
    logic [i2cras_pkg::CNT_W-1:0]  fill_ptr;
    logic [i2cras_pkg::BYTE_W-1:0] tx_bytes [BUF_DEPTH];

    i2cras_pkg::t_out_word predicted_words [$];
    int                    fail_count = 0;

    function automatic i2cras_pkg::t_out_word sequence_step(input i2cras_pkg::t_in_word w);
        i2cras_pkg::t_out_word r;
        r = '0;
        r.accepted = 1'b1;
        case (w.action) inside
            i2cras_pkg::ACT_LOAD: begin
                if (fill_ptr < BUF_DEPTH) begin
                    tx_bytes[fill_ptr] = w.data_byte;
                    fill_ptr = fill_ptr + 1'b1;
                end
            end
            i2cras_pkg::ACT_START_WR, i2cras_pkg::ACT_START_RD: begin
                if (seq_mode != i2cras_pkg::MODE_IDLE) begin
                    r.accepted = 1'b0;
                end else begin
                    seq_mode = i2cras_pkg::MODE_REG;
                    reg_q    = w.register_address;
                    dev_q    = w.dev_address;
                    rx_idx   = '0;
                    tx_idx   = '0;
                    fill_ptr = '0;
                    if (w.action == i2cras_pkg::ACT_START_WR) begin
                        tx_left = (w.byte_count > BUF_DEPTH)
                                  ? i2cras_pkg::CNT_W'(BUF_DEPTH) : w.byte_count;
                        rx_left = '0;
                    end else begin
                        rx_left = (w.byte_count > i2cras_pkg::RX_LIMIT)
                                  ? i2cras_pkg::RX_LIMIT : w.byte_count;
                        tx_left = '0;
                    end
                    r.start_cond     = 1'b1;
                    r.transmit_dir   = 1'b1;
                    r.target_address = dev_q;
                end
            end
            i2cras_pkg::ACT_TX_READY: begin
                case (seq_mode)
                    i2cras_pkg::MODE_REG: begin
                        r.transmit_dir = 1'b1;
                        r.send_valid   = 1'b1;
                        r.send_data    = reg_q;
                        seq_mode = (rx_left != 0) ? i2cras_pkg::MODE_SWITCH
                                                  : i2cras_pkg::MODE_TXDATA;
                    end
                    i2cras_pkg::MODE_SWITCH: begin
                        seq_mode         = i2cras_pkg::MODE_RXDATA;
                        r.start_cond     = 1'b1;
                        r.target_address = dev_q;
                        r.stop_cond      = (rx_left == 1);
                    end
                    i2cras_pkg::MODE_TXDATA: begin
                        if (tx_left != 0) begin
                            r.transmit_dir = 1'b1;
                            r.send_valid   = 1'b1;
                            r.send_data    = tx_bytes[tx_idx];
                            tx_idx  = tx_idx + 1'b1;
                            tx_left = tx_left - 1'b1;
                        end else begin
                            r.stop_cond = 1'b1;
                            r.done_res  = 1'b1;
                            seq_mode    = i2cras_pkg::MODE_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            i2cras_pkg::ACT_RX_BYTE: begin
                if (seq_mode == i2cras_pkg::MODE_RXDATA) begin
                    if (rx_left != 0) begin
                        r.rx_valid    = 1'b1;
                        r.rx_data     = w.data_byte;
                        r.rx_position = rx_idx;
                        rx_idx  = rx_idx + 1'b1;
                        rx_left = rx_left - 1'b1;
                    end
                    if (rx_left == 1) begin
                        r.stop_cond = 1'b1;
                    end else if (rx_left == 0) begin
                        seq_mode   = i2cras_pkg::MODE_IDLE;
                        r.done_res = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.busy_res = (seq_mode != i2cras_pkg::MODE_IDLE);
        return r;
    endfunction

    function automatic string word_text(input i2cras_pkg::t_out_word r);
        return $sformatf({"acc=%0d start=%0d stop=%0d dir=%0d send=%0d/%02h addr=%02h ",
                          "rx=%0d/%02h@%0d done=%0d busy=%0d"},
                         r.accepted, r.start_cond, r.stop_cond, r.transmit_dir,
                         r.send_valid, r.send_data, r.target_address, r.rx_valid,
                         r.rx_data, r.rx_position, r.done_res, r.busy_res);
    endfunction

    function automatic string field_diffs(input i2cras_pkg::t_out_word e,
                                          input i2cras_pkg::t_out_word a);
        string s;
        s = "";
        if (a.accepted       !== e.accepted)       s = {s, " accepted"};
        if (a.start_cond     !== e.start_cond)     s = {s, " start_cond"};
        if (a.stop_cond      !== e.stop_cond)      s = {s, " stop_cond"};
        if (a.transmit_dir   !== e.transmit_dir)   s = {s, " transmit_dir"};
        if (a.send_valid     !== e.send_valid)     s = {s, " send_valid"};
        if (a.send_data      !== e.send_data)      s = {s, " send_data"};
        if (a.target_address !== e.target_address) s = {s, " target_address"};
        if (a.rx_valid       !== e.rx_valid)       s = {s, " rx_valid"};
        if (a.rx_data        !== e.rx_data)        s = {s, " rx_data"};
        if (a.rx_position    !== e.rx_position)    s = {s, " rx_position"};
        if (a.done_res       !== e.done_res)       s = {s, " done_res"};
        if (a.busy_res       !== e.busy_res)       s = {s, " busy_res"};
        return s;
    endfunction

    always @(posedge i_clk) begin
        i2cras_pkg::t_out_word got;
        i2cras_pkg::t_out_word want;
        string                 diffs;
        if (!i_rst_n) begin
            seq_mode = i2cras_pkg::MODE_IDLE;
            reg_q    = '0;
            dev_q    = '0;
            rx_left  = '0;
            tx_left  = '0;
            rx_idx   = '0;
            tx_idx   = '0;
            fill_ptr = '0;
            predicted_words.delete();
        end else begin
            if (i_words.valid === 1'b1 && i_words.ready === 1'b1)
                predicted_words.push_back(sequence_step(i_words.data));
            if (i_results.valid === 1'b1 && i_results.ready === 1'b1) begin
                got = i_results.data;
                if (predicted_words.size() == 0) begin
                    diffs = " unexpected";
                    want  = '0;
                end else begin
                    want  = predicted_words.pop_front();
                    diffs = field_diffs(want, got);
                end
                if (diffs != "") begin
                    if (fail_count < 10)
                        $display("%0t mismatch:%s\n  exp %s\n  got %s", $realtime, diffs,
                                 word_text(want), word_text(got));
                    fail_count++;
                end
            end
        end
        o_pending   <= predicted_words.size();
        o_err_count <= fail_count;
    end

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_DEPTH       = 32;
    localparam int WORDS_PER_PHASE = 325;
    localparam int PRESS_PHASE     = 1;
    localparam int HOLD_CYCLES     = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   err_count;
    int   pending;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   phase_no       = 0;
    int   counted_words  = 0;
    bit   hold_done      = 1'b0;

    i2cras_in_if  in_ch ();
    i2cras_out_if out_ch ();

    i2c_register_access_sequencer #(.BUF_DEPTH(BUF_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    i2cras_txn_check #(.BUF_DEPTH(BUF_DEPTH)) txn_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_words     (in_ch),
        .i_results   (out_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always #1 i_clk = ~i_clk;

    function automatic i2cras_pkg::t_in_word rand_word(
            input logic [i2cras_pkg::ACT_W-1:0] act,
            input logic [i2cras_pkg::CNT_W-1:0] cnt);
        i2cras_pkg::t_in_word w;
        w.action           = act;
        w.dev_address      = i2cras_pkg::DEV_W'($urandom);
        w.register_address = i2cras_pkg::BYTE_W'($urandom);
        w.byte_count       = cnt;
        w.data_byte        = i2cras_pkg::BYTE_W'($urandom);
        return w;
    endfunction

    task automatic send_word(input i2cras_pkg::t_in_word w, input bit useful);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (useful)
            counted_words++;
    endtask

    // words the block must reject or ignore in the current mode, plus loads, which it still stores
    task automatic busy_noise(input bit in_rx);
        case ($urandom_range(3))
            0: send_word(rand_word($urandom_range(1) ? i2cras_pkg::ACT_START_WR
                                                     : i2cras_pkg::ACT_START_RD,
                                   i2cras_pkg::CNT_W'($urandom)), 1'b0);
            1: send_word(rand_word(i2cras_pkg::ACT_LOAD, i2cras_pkg::CNT_W'($urandom)), 1'b0);
            2: send_word(rand_word(i2cras_pkg::ACT_W'($urandom_range(2**i2cras_pkg::ACT_W - 1,
                                                      i2cras_pkg::ACT_RX_BYTE + 1)),
                                   i2cras_pkg::CNT_W'($urandom)), 1'b0);
            default: send_word(rand_word(in_rx ? i2cras_pkg::ACT_TX_READY
                                               : i2cras_pkg::ACT_RX_BYTE,
                                         i2cras_pkg::CNT_W'($urandom)), 1'b0);
        endcase
    endtask

    task automatic run_transaction(input i2cras_pkg::t_in_word start, input int noise_pct);
        bit is_read;
        int n;
        is_read = (start.action == i2cras_pkg::ACT_START_RD);
        if (is_read)
            n = (start.byte_count > i2cras_pkg::RX_LIMIT) ? int'(i2cras_pkg::RX_LIMIT)
                                                          : int'(start.byte_count);
        else
            n = (start.byte_count > BUF_DEPTH) ? BUF_DEPTH : int'(start.byte_count);
        send_word(start, 1'b1);
        if (is_read && n != 0) begin
            repeat (2) begin
                if ($urandom_range(99) < noise_pct)
                    busy_noise(1'b0);
                send_word(rand_word(i2cras_pkg::ACT_TX_READY,
                                    i2cras_pkg::CNT_W'($urandom)), 1'b1);
            end
            repeat (n) begin
                if ($urandom_range(99) < noise_pct)
                    busy_noise(1'b1);
                send_word(rand_word(i2cras_pkg::ACT_RX_BYTE,
                                    i2cras_pkg::CNT_W'($urandom)), 1'b1);
            end
        end else begin
            repeat (n + 2) begin
                if ($urandom_range(99) < noise_pct)
                    busy_noise(1'b0);
                send_word(rand_word(i2cras_pkg::ACT_TX_READY,
                                    i2cras_pkg::CNT_W'($urandom)), 1'b1);
            end
        end
    endtask

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase_no == PRESS_PHASE && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        i2cras_pkg::t_in_word          w;
        logic [i2cras_pkg::CNT_W-1:0] cnt;
        int                           pick;
        bit                           is_read;

        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle: transmit ready, byte received and unused codes are all ignored
        for (int a = i2cras_pkg::ACT_TX_READY; a < 2**i2cras_pkg::ACT_W; a++)
            send_word(rand_word(i2cras_pkg::ACT_W'(a), i2cras_pkg::CNT_W'($urandom)), 1'b1);

        // zero-byte read then zero-byte write, before the store holds anything
        w = rand_word(i2cras_pkg::ACT_START_RD, '0);
        w.dev_address      = '1;
        w.register_address = '1;
        run_transaction(w, 0);
        w = rand_word(i2cras_pkg::ACT_START_WR, '0);
        w.dev_address      = '0;
        w.register_address = '0;
        run_transaction(w, 0);

        // fill the whole store, last load ignored
        for (int i = 0; i <= BUF_DEPTH; i++) begin
            w = rand_word(i2cras_pkg::ACT_LOAD, i2cras_pkg::CNT_W'($urandom));
            if (i == 0)
                w.data_byte = '0;
            else if (i == 1)
                w.data_byte = '1;
            send_word(w, 1'b1);
        end

        run_transaction(rand_word(i2cras_pkg::ACT_START_WR, i2cras_pkg::CNT_W'(3)), 100);
        run_transaction(rand_word(i2cras_pkg::ACT_START_RD, i2cras_pkg::CNT_W'(1)), 100);
        run_transaction(rand_word(i2cras_pkg::ACT_START_RD, i2cras_pkg::CNT_W'(2)), 0);

        for (int p = 1; p <= 4; p++) begin
            case (p)
                1: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                2: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                3: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            phase_no      = p;
            counted_words = 0;
            while (counted_words < WORDS_PER_PHASE) begin
                if ($urandom_range(99) < 15)
                    send_word(rand_word(i2cras_pkg::ACT_W'($urandom_range(
                                            2**i2cras_pkg::ACT_W - 1,
                                            i2cras_pkg::ACT_TX_READY)),
                                        i2cras_pkg::CNT_W'($urandom)), 1'b0);
                is_read = 1'($urandom_range(1));
                if (!is_read)
                    repeat ($urandom_range(3))
                        send_word(rand_word(i2cras_pkg::ACT_LOAD,
                                            i2cras_pkg::CNT_W'($urandom)), 1'b1);
                pick = $urandom_range(99);
                if (pick < 70)
                    cnt = i2cras_pkg::CNT_W'($urandom_range(6));
                else if (pick < 90)
                    cnt = i2cras_pkg::CNT_W'($urandom_range(32, 7));
                else
                    cnt = i2cras_pkg::CNT_W'($urandom_range(2**i2cras_pkg::CNT_W - 1, 33));
                run_transaction(rand_word(is_read ? i2cras_pkg::ACT_START_RD
                                                  : i2cras_pkg::ACT_START_WR, cnt), 10);
            end
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #400_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
